### rtl/mmtd_pkg.sv
// Shared types, constants and bit-packing helpers for the MFM track decoder.
package mmtd_pkg;

  localparam int unsigned MaxWords  = 2048;
  localparam int unsigned IdxW      = $clog2(MaxWords);
  localparam int unsigned TwW       = 12;
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QPtrW     = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW     = $clog2(QDepth + 1);

  localparam logic [31:0]    MfmMask       = 32'h5555_5555;
  localparam logic [TwW-1:0] TwReset       = 12'd1500;
  localparam logic [31:0]    SyncReset     = 32'ha425_a425;
  localparam logic [31:0]    PadReset      = 32'h5554_5554;
  localparam logic [31:0]    SigReset      = 32'h5448_4242;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_TRACK_WORDS = 2'd0,
    REG_SYNC        = 2'd1,
    REG_PAD         = 2'd2,
    REG_SIGNATURE   = 2'd3
  } reg_idx_e;

  // Decoder phase
  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_PAD   = 3'd1,
    PH_SIG   = 3'd2,
    PH_LEN   = 3'd3,
    PH_CSUM  = 3'd4,
    PH_DODD  = 3'd5,
    PH_DEVEN = 3'd6
  } phase_e;

  // One decoded result beat
  typedef struct packed {
    logic [31:0]     data;
    logic [IdxW-1:0] index;
    logic            last;
    logic            ok;
  } res_t;

  // Keep the data bits (even positions) of a raw word
  function automatic logic [15:0] pack_bits(logic [31:0] raw);
    logic [15:0] v;
    v = '0;
    for (int i = 0; i < 16; i++) begin
      v[i] = raw[2*i];
    end
    return v;
  endfunction

  // Spread 16 stored bits back to the even positions
  function automatic logic [31:0] unpack_bits(logic [15:0] v);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[2*i] = v[i];
    end
    return r;
  endfunction

  function automatic logic [31:0] mfm_join(logic [31:0] odd, logic [31:0] even);
    return ((odd & MfmMask) << 1) | (even & MfmMask);
  endfunction

endpackage

### rtl/mmtd_front.sv
// Front end: bit window, sync hunt, header checks, odd-bit store and word decode.
module mmtd_front
  import mmtd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        accept_i,
  input  logic        raw_bit_i,
  output logic        push_o,
  output res_t        push_data_o
);

  logic [TwW-1:0]  track_words_q;
  logic [31:0]     sync_q, pad_q, sig_q;

  logic [31:0]     window_q, window_d;
  phase_e          phase_q, phase_d;
  logic [5:0]      bit_count_q, bit_count_d;
  logic [IdxW-1:0] word_count_q, word_count_d;
  logic [31:0]     hdr_odd_q, hdr_odd_d;
  logic [31:0]     exp_csum_q, exp_csum_d;
  logic [31:0]     xor_q, xor_d;

  logic [15:0]     store_mem [MaxWords];
  logic [15:0]     rd_q;

  logic [6:0]      bc;
  logic [31:0]     hdr_dec, data_dec, xor_next;
  logic [IdxW-1:0] last_idx;
  logic            words_ok, at_last, mem_we;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_words_q <= TwReset;
      sync_q        <= SyncReset;
      pad_q         <= PadReset;
      sig_q         <= SigReset;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_TRACK_WORDS: track_words_q <= cfg_data_i[TwW-1:0];
        REG_SYNC:        sync_q        <= cfg_data_i;
        REG_PAD:         pad_q         <= cfg_data_i;
        REG_SIGNATURE:   sig_q         <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Shared decode terms
  assign window_d = {window_q[30:0], raw_bit_i};
  assign bc       = {1'b0, bit_count_q} + 7'd1;
  assign hdr_dec  = mfm_join(hdr_odd_q, window_d);
  assign data_dec = mfm_join(unpack_bits(rd_q) << 1 >> 1, window_d)
                    | (unpack_bits(rd_q) << 1);
  assign xor_next = xor_q ^ data_dec;
  assign words_ok = (track_words_q != '0) && (track_words_q <= TwW'(MaxWords));

  // Clamp the last index so the count always ends
  always_comb begin
    if (track_words_q == '0) begin
      last_idx = '0;
    end else if (track_words_q > TwW'(MaxWords)) begin
      last_idx = IdxW'(MaxWords - 1);
    end else begin
      last_idx = IdxW'(track_words_q - TwW'(1));
    end
  end
  assign at_last = (word_count_q >= last_idx);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_HUNT: begin
        if (window_d == sync_q) phase_d = PH_PAD;
      end
      PH_PAD: begin
        if (bc == 7'd32) phase_d = (window_d == pad_q) ? PH_SIG : PH_HUNT;
      end
      PH_SIG: begin
        if (bc == 7'd64) phase_d = (hdr_dec == sig_q) ? PH_LEN : PH_HUNT;
      end
      PH_LEN: begin
        if (bc == 7'd64) begin
          phase_d = (words_ok && hdr_dec == {18'd0, track_words_q, 2'b00}) ?
                    PH_CSUM : PH_HUNT;
        end
      end
      PH_CSUM: begin
        if (bc == 7'd64) phase_d = PH_DODD;
      end
      PH_DODD: begin
        if (bc == 7'd32 && at_last) phase_d = PH_DEVEN;
      end
      PH_DEVEN: begin
        if (bc == 7'd32 && at_last) phase_d = PH_HUNT;
      end
      default: phase_d = PH_HUNT;
    endcase
  end

  // Datapath updates and result beat
  always_comb begin
    bit_count_d  = bit_count_q;
    word_count_d = word_count_q;
    hdr_odd_d    = hdr_odd_q;
    exp_csum_d   = exp_csum_q;
    xor_d        = xor_q;
    mem_we       = 1'b0;
    push_o       = 1'b0;
    push_data_o  = '{data: data_dec, index: word_count_q,
                     last: at_last, ok: at_last && (xor_next == exp_csum_q)};
    case (phase_q)
      PH_HUNT: begin
        if (window_d == sync_q) bit_count_d = '0;
      end
      PH_PAD: begin
        bit_count_d = (bc == 7'd32) ? 6'd0 : bc[5:0];
      end
      PH_SIG, PH_LEN, PH_CSUM: begin
        bit_count_d = bc[5:0];
        if (bc == 7'd32) begin
          hdr_odd_d = window_d;
        end else if (bc == 7'd64 && phase_q == PH_CSUM) begin
          exp_csum_d   = hdr_dec;
          xor_d        = '0;
          word_count_d = '0;
        end
      end
      PH_DODD, PH_DEVEN: begin
        bit_count_d = bc[5:0];
        if (bc == 7'd32) begin
          bit_count_d  = '0;
          word_count_d = at_last ? '0 : word_count_q + IdxW'(1);
          if (phase_q == PH_DODD) begin
            mem_we = 1'b1;
          end else begin
            xor_d  = xor_next;
            push_o = accept_i;
          end
        end
      end
      default: bit_count_d = '0;
    endcase
  end

  // State registers, advance on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q     <= '0;
      phase_q      <= PH_HUNT;
      bit_count_q  <= '0;
      word_count_q <= '0;
      hdr_odd_q    <= '0;
      exp_csum_q   <= '0;
      xor_q        <= '0;
    end else if (accept_i) begin
      window_q     <= window_d;
      phase_q      <= phase_d;
      bit_count_q  <= bit_count_d;
      word_count_q <= word_count_d;
      hdr_odd_q    <= hdr_odd_d;
      exp_csum_q   <= exp_csum_d;
      xor_q        <= xor_d;
    end
  end

  // Odd-bit store: write on odd word end, read the current word every cycle
  always_ff @(posedge clk_i) begin
    if (accept_i && mem_we) begin
      store_mem[word_count_q] <= pack_bits(window_d);
    end
    rd_q <= store_mem[word_count_q];
  end

endmodule

### rtl/mmtd_fifo.sv
// Short result queue between the decoder front end and the output stage.
module mmtd_fifo
  import mmtd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t push_data_i,
  input  logic pop_i,
  output res_t pop_data_o,
  output logic empty_o,
  output logic full_o
);

  res_t             entry_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;

  assign empty_o    = (count_q == '0);
  assign full_o     = (count_q == QCntW'(QDepth));
  assign pop_data_o = entry_q[rd_ptr_q];

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + QCntW'(1);
        2'b01:   count_q <= count_q - QCntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  // Hold entry payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/mmtd_back.sv
// Output stage: registers one result beat and holds it while the receiver stalls.
module mmtd_back
  import mmtd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_empty_i,
  input  res_t q_data_i,
  output logic q_pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);

  logic out_valid_q;
  res_t out_data_q;

  // Load a new beat when the register is free or being drained
  assign q_pop_o     = !q_empty_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_data_q <= q_data_i;
    end
  end

endmodule

### rtl/mfm_even_odd_track_decoder_core.sv
// Top level of the even/odd MFM track decoder.
//
// Input channel: one raw disk bit per beat (in_valid_i/in_ready_o, raw_bit_i).
// The bit enters a 32-bit window; the decoder hunts for the sync word, checks
// the pad word and the signature, length and checksum header longs, stores the
// odd-half data bits and emits one decoded word per even-half raw word.
// Output channel: out_valid_o/out_ready_i with data_word_o, word_index_o,
// last_o and checksum_ok_o (checksum_ok_o is meaningful with last_o).
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i (0 track words,
// 1 sync, 2 pad, 3 signature) and cfg_data_i; always ready, write when idle.
// Throughput: one bit per cycle while the queue is not full, set by the front
// end; the odd-bit store is read ahead of use through its registered port.
// A word is written into the queue at the edge that accepts its final even
// bit and moves on to the output register once that register is free.
// Reset clears the window, phase and counters and loads the register defaults;
// the odd-bit store is left as is. When the receiver stalls, results collect
// in the two-entry queue and the output register; once the queue is full,
// in_ready_o drops until a beat leaves.
module mfm_even_odd_track_decoder_core
  import mmtd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  logic [31:0]     cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            raw_bit_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [31:0]     data_word_o,
  output logic [IdxW-1:0] word_index_o,
  output logic            last_o,
  output logic            checksum_ok_o
);

  logic accept, push, q_pop, q_empty, q_full;
  res_t push_data, q_data, out_data;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full;
  assign accept      = in_valid_i && in_ready_o;

  mmtd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .raw_bit_i   (raw_bit_i),
    .push_o      (push),
    .push_data_o (push_data)
  );

  mmtd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (q_pop),
    .pop_data_o  (q_data),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  mmtd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign data_word_o   = out_data.data;
  assign word_index_o  = out_data.index;
  assign last_o        = out_data.last;
  assign checksum_ok_o = out_data.ok;

endmodule
